### src/jdb_pkg.sv
package jdb_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ZW           = 26;   // angle accumulator width, 2^-16 degree
    localparam int AW           = 28;   // cordic x/y width

    localparam logic [ZW-1:0] DEG45  = ZW'(2949120);
    localparam logic [ZW-1:0] DEG90  = ZW'(5898240);
    localparam logic [ZW-1:0] DEG180 = ZW'(11796480);
    localparam logic [ZW-1:0] DEG360 = ZW'(23592960);
    localparam logic [14:0]   BEARING_WRAP = 15'd23040;
    localparam logic [14:0]   MOVE_OFFSET  = 15'd2880;

    typedef struct packed {
        logic [12:0] intensity;
        logic [14:0] bearing;
        logic        centered;
    } t_lane_res;

    function automatic logic [ZW-1:0] atan_entry(input logic [3:0] i);
        logic [ZW-1:0] r;
        case (i)
            4'd0:    r = ZW'(2949120);
            4'd1:    r = ZW'(1740967);
            4'd2:    r = ZW'(919879);
            4'd3:    r = ZW'(466945);
            4'd4:    r = ZW'(234379);
            4'd5:    r = ZW'(117304);
            4'd6:    r = ZW'(58666);
            4'd7:    r = ZW'(29335);
            4'd8:    r = ZW'(14668);
            4'd9:    r = ZW'(7334);
            4'd10:   r = ZW'(3667);
            4'd11:   r = ZW'(1833);
            4'd12:   r = ZW'(917);
            4'd13:   r = ZW'(458);
            4'd14:   r = ZW'(229);
            default: r = ZW'(115);
        endcase
        return r;
    endfunction

endpackage

### src/joystick_deadzone_bearing.sv
// an accepted input beat runs the lanes' 24-step root/cordic loop, 38-step quotient
//   loop, finish step and done hand-off before it is registered as the output beat;
//   only one beat is in flight, the next being accepted once that result is taken
// stalls: a finished result waits in the lanes while the output beat is held
// reset: synchronous active-low i_rst_n; dead zone returns to 20, held aim
//   bearing to 0, output empties
module joystick_deadzone_bearing
    import jdb_pkg::*;
#(
    parameter int FULL_SCALE = 100
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // left_x, left_y, right_x, right_y
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // move_intensity, move_bearing, aim_intensity, aim_bearing
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_wdata
);

    logic [6:0]  r_dz;
    logic        r_busy;
    logic [14:0] r_held;
    logic        r_oval;
    logic [55:0] r_odata;
    logic        r_pend;
    logic        start;
    logic        res_ready;
    logic        take;
    logic        done_l, done_r;
    t_lane_res   res_l, res_r;
    logic [14:0] aim_b;

    // one beat in flight; a new one may start while the output waits
    assign s_axis_tready = !r_busy;
    assign start = s_axis_tvalid && s_axis_tready;

    // lane result stays stable until the next start, so it can wait here
    assign res_ready = done_l || r_pend;
    assign take = res_ready && (!r_oval || m_axis_tready);

    // movement lane
    jdb_lane #(.FULL_SCALE(FULL_SCALE)) u_left (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start),
        .i_x(s_axis_tdata[7:0]), .i_y(s_axis_tdata[15:8]),
        .i_dead_zone(r_dz), .o_done(done_l), .o_res(res_l)
    );

    // aiming lane
    jdb_lane #(.FULL_SCALE(FULL_SCALE)) u_right (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start),
        .i_x(s_axis_tdata[23:16]), .i_y(s_axis_tdata[31:24]),
        .i_dead_zone(r_dz), .o_done(done_r), .o_res(res_r)
    );

    // merge: centered aim keeps the held bearing
    assign aim_b = res_r.centered ? r_held : res_r.bearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dz   <= 7'd20;
            r_busy <= 1'b0;
            r_held <= '0;
            r_oval <= 1'b0;
            r_pend <= 1'b0;
        end else begin
            if (i_cfg_we) r_dz <= i_cfg_wdata;
            if (start) begin
                r_busy <= 1'b1;
            end else if (take) begin
                r_busy <= 1'b0;
            end
            if (take) begin
                r_pend <= 1'b0;
            end else if (done_l) begin
                r_pend <= 1'b1;
            end
            if (take) begin
                r_oval <= 1'b1;
                r_held <= aim_b;
            end else if (m_axis_tready) begin
                r_oval <= 1'b0;
            end
        end
        if (take) begin
            r_odata <= {aim_b, res_r.intensity,
                        (res_l.centered ? MOVE_OFFSET : res_l.bearing + MOVE_OFFSET),
                        res_l.intensity};
        end
    end

    logic unused_done;
    assign unused_done = done_r;

    assign m_axis_tvalid = r_oval;
    assign m_axis_tdata  = r_odata;

endmodule

### src/jdb_lane.sv
module jdb_lane
    import jdb_pkg::*;
#(
    parameter int FULL_SCALE = 100
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [7:0]      i_x,
    input  logic [7:0]      i_y,
    input  logic [6:0]      i_dead_zone,
    output logic            o_done,
    output t_lane_res       o_res
);

    // wide enough for both the full scale and any 7-bit dead zone
    localparam int FW = (FULL_SCALE > 127 ? $clog2(FULL_SCALE + 1) : 7) + 1;
    localparam int MW = 24;     // root of s<<24, s <= 2^15
    localparam int QW = 38;     // quotient register width

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RUN  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_FIN  = 3'd3;

    logic [2:0]  r_state, n_state;
    logic [4:0]  r_cnt, n_cnt;
    logic [5:0]  r_dcnt, n_dcnt;
    logic        r_done;

    // square root (bit pair per cycle)
    logic [47:0] r_rem, n_rem;
    logic [MW-1:0] r_root, n_root;
    logic [47:0] r_rad, n_rad;
    // cordic
    logic signed [AW-1:0] r_a, r_b, n_a, n_b;
    logic signed [ZW:0]   r_z, n_z;
    // quadrant info
    logic r_swap, r_uneg, r_vneg, r_cen, r_zero_i, r_full_i;
    logic [6:0] r_dz;
    // divider
    logic [QW-1:0] r_num, n_num;
    logic [QW-1:0] r_quo, n_quo;
    logic [FW-1:0] r_den;
    t_lane_res r_res, n_res;

    logic signed [8:0] sx, sv;
    logic [8:0] au, av;
    logic [15:0] ssum;
    logic [13:0] dd;

    always_comb begin
        sx = {i_x[7], i_x};
        sv = -{i_y[7], i_y};
        au = sx[8] ? -sx : sx;
        av = sv[8] ? -sv : sv;
        ssum = 16'(au * au) + 16'(av * av);
        dd = 14'(i_dead_zone * i_dead_zone);
    end

    logic [49:0] trial;
    logic signed [AW-1:0] da, db;
    logic signed [ZW:0] zc;
    logic [ZW-1:0] t, total;
    logic [25:0] rnd;
    logic [14:0] brg;
    logic [QW:0] dsub;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_dcnt  = r_dcnt;
        n_rem   = r_rem;
        n_root  = r_root;
        n_rad   = r_rad;
        n_a     = r_a;
        n_b     = r_b;
        n_z     = r_z;
        n_num   = r_num;
        n_quo   = r_quo;
        n_res   = r_res;
        trial   = '0;
        da      = '0;
        db      = '0;
        zc      = '0;
        t       = '0;
        total   = '0;
        rnd     = '0;
        brg     = '0;
        dsub    = '0;
        case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                n_rem = '0;
                n_root = '0;
                n_rad = {ssum, 32'd0} >> 8;
                n_z = '0;
                n_quo = '0;
                if (au <= av) begin
                    n_a = AW'({av, 16'd0});
                    n_b = AW'({au, 16'd0});
                end else begin
                    n_a = AW'({au, 16'd0});
                    n_b = AW'({av, 16'd0});
                end
                if (i_start) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                // one root bit
                trial = {r_rem, r_rad[47:46]} - {24'd0, r_root, 2'b01};
                if (!trial[49]) begin
                    n_rem  = trial[47:0];
                    n_root = {r_root[MW-2:0], 1'b1};
                end else begin
                    n_rem  = {r_rem[45:0], r_rad[47:46]};
                    n_root = {r_root[MW-2:0], 1'b0};
                end
                n_rad = {r_rad[45:0], 2'b00};
                // one cordic step, shifts truncate toward zero
                if (r_cnt < 5'd16) begin
                    da = r_b[AW-1] ? -((-r_b) >>> r_cnt[3:0]) : (r_b >>> r_cnt[3:0]);
                    db = r_a[AW-1] ? -((-r_a) >>> r_cnt[3:0]) : (r_a >>> r_cnt[3:0]);
                    if (!r_b[AW-1]) begin
                        n_a = r_a + da;
                        n_b = r_b - db;
                        n_z = r_z + $signed({1'b0, atan_entry(r_cnt[3:0])});
                    end else begin
                        n_a = r_a - da;
                        n_b = r_b + db;
                        n_z = r_z - $signed({1'b0, atan_entry(r_cnt[3:0])});
                    end
                end
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd23) begin
                    n_state = S_DIV;
                    n_dcnt  = '0;
                    n_num   = QW'(n_root) - QW'({r_dz, 12'd0});
                end
            end
            S_DIV: begin
                // restoring divide, one quotient bit per cycle, 38 bits
                dsub = {r_quo, r_num[QW-1]} - (QW+1)'(r_den);
                if (!dsub[QW]) begin
                    n_quo = dsub[QW-1:0];
                    n_num = {r_num[QW-2:0], 1'b1};
                end else begin
                    n_quo = {r_quo[QW-2:0], r_num[QW-1]};
                    n_num = {r_num[QW-2:0], 1'b0};
                end
                n_dcnt = r_dcnt + 6'd1;
                if (r_dcnt == 6'(QW - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                zc = r_z[ZW] ? '0 : r_z;
                t = (zc > $signed({1'b0, DEG45})) ? DEG45 : zc[ZW-1:0];
                if (r_swap) t = DEG90 - t;
                if (!r_uneg) total = r_vneg ? DEG180 - t : t;
                else total = r_vneg ? DEG180 + t : DEG360 - t;
                rnd = (total + 26'd512) >> 10;
                brg = rnd[14:0];
                if (brg >= BEARING_WRAP) brg = brg - BEARING_WRAP;
                n_res.bearing = brg;
                n_res.centered = r_cen;
                if (r_zero_i) n_res.intensity = '0;
                else if (r_full_i || r_num > QW'(4096)) n_res.intensity = 13'd4096;
                else n_res.intensity = r_num[12:0];
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_FIN);
        end
        r_cnt  <= n_cnt;
        r_dcnt <= n_dcnt;
        r_rem  <= n_rem;
        r_root <= n_root;
        r_rad  <= n_rad;
        r_a    <= n_a;
        r_b    <= n_b;
        r_z    <= n_z;
        r_num  <= n_num;
        r_quo  <= n_quo;
        r_res  <= n_res;
        if (r_state == S_IDLE && i_start) begin
            r_swap   <= !(au <= av);
            r_uneg   <= sx[8];
            r_vneg   <= sv[8];
            r_cen    <= (i_x == 8'd0) && (i_y == 8'd0);
            r_zero_i <= {2'b00, ssum} <= {4'd0, dd} ? 1'b1 : 1'b0;
            r_full_i <= (FW'(FULL_SCALE) <= FW'(i_dead_zone));
            r_dz     <= i_dead_zone;
            r_den    <= FW'(FULL_SCALE) - FW'(i_dead_zone);
        end
    end

    // divider: quotient left in r_num after the last step
    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

### test/joystick_deadzone_bearing_test.sv
module joystick_deadzone_bearing_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FULL = 100;
    localparam int LIMIT = 2000000;

    // one sample of both sticks as it travels on the slave side
    typedef struct packed {
        logic signed [7:0] ry;
        logic signed [7:0] rx;
        logic signed [7:0] ly;
        logic signed [7:0] lx;
    } t_sample;

    typedef struct packed {
        logic [14:0] aim_bearing;
        logic [12:0] aim_intensity;
        logic [14:0] move_bearing;
        logic [12:0] move_intensity;
    } t_stick_out;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // left_x, left_y, right_x, right_y
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [55:0] m_axis_tdata;        // move_intensity, move_bearing, aim_intensity, aim_bearing
    logic        i_cfg_we = 0;
    logic [6:0]  i_cfg_wdata = '0;

    joystick_deadzone_bearing #(.FULL_SCALE(FULL)) i_dut (.*);

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // predictor state
    int unsigned dz_model;
    logic [14:0] held_aim;

    t_sample    pending_samples[$];
    t_stick_out expected_beats[$];
    int         send_idle_pct;
    int         recv_stall_pct;
    bit         failed;
    int         cycle_count;

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic logic [12:0] stick_intensity(int x, int y, int unsigned dz);
        longint unsigned s, m, q;
        s = longint'(x * x + y * y);
        if (s <= dz * dz) return 0;
        if (FULL <= dz) return 13'd4096;
        m = int_sqrt(s << 24);
        q = (m - 4096 * dz) / (FULL - dz);
        return (q > 4096) ? 13'd4096 : 13'(q);
    endfunction

    // shift toward zero, as the hardware does
    function automatic longint shift_tz(longint v, int i);
        if (v >= 0) return v >>> i;
        return -((-v) >>> i);
    endfunction

    function automatic longint octant_cordic(longint p, longint q);
        longint a, b, z, da, db;
        a = p * 65536;
        b = q * 65536;
        z = 0;
        for (int i = 0; i < jdb_pkg::CORDIC_STEPS; i++) begin
            da = shift_tz(b, i);
            db = shift_tz(a, i);
            if (b >= 0) begin
                a += da; b -= db; z += longint'(jdb_pkg::atan_entry(4'(i)));
            end else begin
                a -= da; b += db; z -= longint'(jdb_pkg::atan_entry(4'(i)));
            end
        end
        if (z < 0) z = 0;
        if (z > 2949120) z = 2949120;
        return z;
    endfunction

    // clockwise bearing, 1/64 degree; stick must not be centered
    function automatic logic [14:0] stick_bearing(int x, int y);
        longint u, v, au, av, t, total;
        u = x;
        v = -y;
        au = u < 0 ? -u : u;
        av = v < 0 ? -v : v;
        if (au <= av) t = octant_cordic(av, au);
        else t = 5898240 - octant_cordic(au, av);
        if (u >= 0) total = (v >= 0) ? t : 11796480 - t;
        else total = (v < 0) ? 11796480 + t : 23592960 - t;
        return 15'(((total + 512) >>> 10) % 23040);
    endfunction

    function automatic t_stick_out predict_sample(t_sample smp);
        t_stick_out r;
        logic [14:0] mb;
        mb = 0;
        if (smp.lx != 0 || smp.ly != 0) mb = stick_bearing(smp.lx, smp.ly);
        if (smp.rx != 0 || smp.ry != 0) held_aim = stick_bearing(smp.rx, smp.ry);
        r.move_intensity = stick_intensity(smp.lx, smp.ly, dz_model);
        r.move_bearing   = mb + 15'd2880;
        r.aim_intensity  = stick_intensity(smp.rx, smp.ry, dz_model);
        r.aim_bearing    = held_aim;
        return r;
    endfunction

    // driver: one sample beat at a time from the pending queue
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_beats.push_back(predict_sample(t_sample'(s_axis_tdata)));
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_axis_tvalid <= 1;
                    s_axis_tdata  <= pending_samples.pop_front();
                end else begin
                    s_axis_tvalid <= 0;
                end
            end
        end
    end

    // monitor: compare each output beat with the oldest prediction
    always @(posedge i_clk) begin
        t_stick_out got, want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_stick_out'(m_axis_tdata);
                if (expected_beats.size() == 0) begin
                    $display("%0t unexpected beat %h", $realtime, m_axis_tdata);
                    failed = 1;
                end else begin
                    want = expected_beats.pop_front();
                    if (got.move_intensity !== want.move_intensity) begin
                        $display("%0t move_intensity exp %0d got %0d", $realtime,
                                 want.move_intensity, got.move_intensity);
                        failed = 1;
                    end
                    if (got.move_bearing !== want.move_bearing) begin
                        $display("%0t move_bearing exp %0d got %0d", $realtime,
                                 want.move_bearing, got.move_bearing);
                        failed = 1;
                    end
                    if (got.aim_intensity !== want.aim_intensity) begin
                        $display("%0t aim_intensity exp %0d got %0d", $realtime,
                                 want.aim_intensity, got.aim_intensity);
                        failed = 1;
                    end
                    if (got.aim_bearing !== want.aim_bearing) begin
                        $display("%0t aim_bearing exp %0d got %0d", $realtime,
                                 want.aim_bearing, got.aim_bearing);
                        failed = 1;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic signed [7:0] rand_defl();
        case ($urandom_range(9))
            0: return -8'sd128;
            1: return 8'sd127;
            2: return 0;
            3: return 8'($urandom_range(255));
            default: return 8'($signed($urandom_range(200)) - 100);
        endcase
    endfunction

    function automatic t_sample mk(int a, int b, int c, int d);
        t_sample s;
        s.lx = 8'(a); s.ly = 8'(b); s.rx = 8'(c); s.ry = 8'(d);
        return s;
    endfunction

    // wait until the block has drained, then write the dead zone
    task automatic set_dead_zone(int unsigned dz);
        while (pending_samples.size() > 0 || s_axis_tvalid || expected_beats.size() > 0)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        i_cfg_we    <= 1;
        i_cfg_wdata <= 7'(dz);
        @(posedge i_clk);
        i_cfg_we    <= 0;
        dz_model = dz;
    endtask

    initial begin
        int unsigned zones[6];
        zones = '{20, 0, 99, 50, 1, 127};
        dz_model = 20;
        held_aim = 0;
        failed = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: centers, axes, diagonals, extremes, dead zone edge
        pending_samples.push_back(mk(0, 0, 0, 0));
        pending_samples.push_back(mk(0, -100, 100, 0));
        pending_samples.push_back(mk(100, 0, 0, 0));
        pending_samples.push_back(mk(0, 100, -100, 0));
        pending_samples.push_back(mk(-100, 0, 0, -100));
        pending_samples.push_back(mk(-128, -128, 127, 127));
        pending_samples.push_back(mk(127, -128, -128, 127));
        pending_samples.push_back(mk(20, 0, 0, 20));
        pending_samples.push_back(mk(21, 0, 0, 0));
        pending_samples.push_back(mk(12, 16, -12, -16));
        pending_samples.push_back(mk(-1, 1, 1, -1));
        pending_samples.push_back(mk(-70, -71, 71, 70));
        pending_samples.push_back(mk(-1, -100, -1, 100));
        pending_samples.push_back(mk(1, -100, 0, 0));

        // one phase per dead-zone setting, idling patterns rotating
        for (int ph = 0; ph < 6; ph++) begin
            set_dead_zone(zones[ph]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
                default: begin send_idle_pct = 11; recv_stall_pct = 11; end
            endcase
            for (int k = 0; k < 225; k++) begin
                // leave the aiming stick centered now and then so the hold shows
                if ($urandom_range(5) == 0)
                    pending_samples.push_back(mk(rand_defl(), rand_defl(), 0, 0));
                else
                    pending_samples.push_back(mk(rand_defl(), rand_defl(),
                                                 rand_defl(), rand_defl()));
            end
        end

        while (pending_samples.size() > 0 || s_axis_tvalid || expected_beats.size() > 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (!failed && expected_beats.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

### files.f
src/jdb_pkg.sv
src/jdb_lane.sv
src/joystick_deadzone_bearing.sv
test/joystick_deadzone_bearing_test.sv
